/* rtl/core/gzf_pkg.sv */
// Package for the gas Z-factor solver: value types, DAK constants, exp factor table,
// sequencer encodings and the request struct of the shared multiplier.
// No dependencies.
package gzf_pkg;

  localparam int VAL_W = 42;              // signed Q16, saturated to +-2^40
  localparam int MAG_W = VAL_W - 1;       // magnitude incl. the value 2^40
  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t LIMV   = 42'sh100_0000_0000;
  localparam val_t ONE    = 42'sd65536;
  localparam val_t Z_MAXV = 42'sd524287;
  localparam val_t Z_MINV = -42'sd524288;
  localparam val_t EXP_XMAX = 42'sd1048576;   // 16.0
  localparam val_t EXP_ONE24 = 42'sd16777216; // 1.0 in Q24

  localparam val_t C_A1  = 42'sd21398;
  localparam val_t C_A2  = -42'sd70124;
  localparam val_t C_A3  = -42'sd34990;
  localparam val_t C_A4  = 42'sd1028;
  localparam val_t C_A5  = -42'sd3385;
  localparam val_t C_A6  = 42'sd35881;
  localparam val_t C_A7  = -42'sd48241;
  localparam val_t C_A8  = 42'sd12085;
  localparam val_t C_A9  = 42'sd6921;
  localparam val_t C_A10 = 42'sd40200;
  localparam val_t C_A11 = 42'sd47251;
  localparam val_t C_027 = 42'sd17695;
  localparam val_t C_DIVG = 42'sd655;

  // digit-serial multiplier
  localparam int MUL_DIG   = 8;
  localparam int MUL_STEPS = (MAG_W + MUL_DIG - 1) / MUL_DIG;
  localparam int MB_W      = MUL_STEPS * MUL_DIG;
  localparam int ACC_W     = MAG_W + MB_W;
  localparam int MUL_CW    = $clog2(MUL_STEPS);

  // restoring divider
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 40;
  localparam int DIV_CW = $clog2(DIV_NW);

  // exp(-x) table walk: integer bits and top fraction bits of x
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_LOWP = 16 - EXP_TABLE_BITS;
  localparam int EXP_TOPB = 19;

  localparam int MAX_ITERATIONS = 64;
  localparam int IT_W = 7;
  localparam int TOL_W = 16;
  localparam int CFG_DW = 16;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_LIM = 1'b1;

  localparam logic [2:0] STAT_CONV  = 3'd0;
  localparam logic [2:0] STAT_DIVG  = 3'd1;
  localparam logic [2:0] STAT_LIMIT = 3'd2;
  localparam logic [2:0] STAT_NEGP  = 3'd3;
  localparam logic [2:0] STAT_BADT  = 3'd4;

  typedef enum logic [1:0] {MM_Q16, MM_Q24, MM_RAW} mul_mode_e;

  typedef struct packed {
    val_t      a;
    val_t      b;
    mul_mode_e mode;
  } mul_req_t;

  typedef enum logic [1:0] {MS_IDLE, MS_RUN, MS_FIN} mul_st_e;
  typedef enum logic {DS_IDLE, DS_RUN} div_st_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_HEAD, ST_EXPI, ST_EXPB, ST_CHECK, ST_OUT
  } st_e;

  // program steps, in execution order; X_BIT and X_RND run between L_T4 and L_T4E
  typedef enum logic [5:0] {
    P_TI, P_T2, P_T3, P_T4, P_T5, P_C1A, P_SA, P_SB, P_C1B, P_C1C,
    P_C2A, P_C2B, P_SC, P_SD, P_C3, P_NUM,
    L_DEN, L_RHO, L_R2, L_R4, L_R5, L_X, L_S1, L_S2, L_W, L_T4,
    L_T4E, L_ZA, L_ZB, L_ZC, L_ZD, X_BIT, X_RND
  } pc_e;

  typedef enum logic [4:0] {
    D_NONE, D_T2, D_T3, D_T4, D_T5, D_C1, D_C2, D_C3, D_S, D_NUM, D_DEN,
    D_R2, D_R5, D_X, D_W, D_T4R, D_E, D_EXP, D_ZN
  } dst_e;

  // exp(-2^k) in Q24 for k = 3 down to -12
  function automatic logic [23:0] exp_fac(input logic [3:0] k);
    logic [23:0] f;
    case (k)
      4'd0:    f = 24'd5628;
      4'd1:    f = 24'd307285;
      4'd2:    f = 24'd2270549;
      4'd3:    f = 24'd6171993;
      4'd4:    f = 24'd10175896;
      4'd5:    f = 24'd13066109;
      4'd6:    f = 24'd14805841;
      4'd7:    f = 24'd15760736;
      4'd8:    f = 24'd16261035;
      4'd9:    f = 24'd16517109;
      4'd10:   f = 24'd16646655;
      4'd11:   f = 24'd16711779;
      4'd12:   f = 24'd16744480;
      4'd13:   f = 24'd16760840;
      4'd14:   f = 24'd16769026;
      4'd15:   f = 24'd16773120;
      default: f = 24'd0;
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/gzf_mul.sv */
// Shared digit-serial signed multiplier with Q16/Q24 rounding, Q16 saturation and a raw mode.
// Depends on gzf_pkg.
module gzf_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  gzf_pkg::mul_req_t req_i,
  output logic             busy_o,
  output logic             done_o,
  output gzf_pkg::val_t    res_o
);
  import gzf_pkg::*;

  mul_st_e st_q, st_d;
  logic [MUL_CW-1:0] cnt_q;
  logic [MAG_W-1:0]  ma_q;
  logic [MB_W-1:0]   mb_q;
  logic [ACC_W-1:0]  acc_q, acc_nx;
  logic              neg_q, done_q;
  mul_mode_e         mode_q;
  val_t              res_q, res_d;
  val_t              abs_a, abs_b;
  logic [MAG_W+MUL_DIG-1:0] pstep;
  logic [ACC_W-1:0]  rnd16, rnd24;
  logic [MAG_W-1:0]  mag;

  assign abs_a = req_i.a[VAL_W-1] ? -req_i.a : req_i.a;
  assign abs_b = req_i.b[VAL_W-1] ? -req_i.b : req_i.b;

  // top digit of b first, accumulator shifts up one digit per step
  assign pstep  = (MAG_W+MUL_DIG)'(ma_q) * (MAG_W+MUL_DIG)'(mb_q[MB_W-1 -: MUL_DIG]);
  assign acc_nx = {acc_q[ACC_W-MUL_DIG-1:0], MUL_DIG'(0)} + ACC_W'(pstep);

  assign rnd16 = acc_q + (ACC_W'(1) << 15);
  assign rnd24 = acc_q + (ACC_W'(1) << 23);

  always_comb begin
    case (mode_q)
      MM_Q16:  mag = (acc_q > (ACC_W'(1) << 56)) ? LIMV[MAG_W-1:0] : rnd16[56:16];
      MM_Q24:  mag = rnd24[MAG_W+23:24];
      MM_RAW:  mag = acc_q[MAG_W-1:0];
      default: mag = '0;
    endcase
    res_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      MS_IDLE: if (start_i) st_d = MS_RUN;
      MS_RUN:  if (cnt_q == MUL_CW'(MUL_STEPS - 1)) st_d = MS_FIN;
      MS_FIN:  st_d = MS_IDLE;
      default: st_d = MS_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (st_q != MS_IDLE);
    done_o = done_q;
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MS_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == MS_FIN);
      if (st_q == MS_RUN) cnt_q <= cnt_q + MUL_CW'(1);
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == MS_IDLE && start_i) begin
      ma_q   <= abs_a[MAG_W-1:0];
      mb_q   <= MB_W'(abs_b[MAG_W-1:0]);
      neg_q  <= req_i.a[VAL_W-1] ^ req_i.b[VAL_W-1];
      mode_q <= req_i.mode;
      acc_q  <= '0;
    end else if (st_q == MS_RUN) begin
      acc_q <= acc_nx;
      mb_q  <= {mb_q[MB_W-MUL_DIG-1:0], MUL_DIG'(0)};
    end
    if (st_q == MS_FIN) res_q <= res_d;
  end

endmodule

/* rtl/core/gzf_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on gzf_pkg.
module gzf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gzf_pkg::DIV_NW-1:0] dividend_i,
  input  logic [gzf_pkg::DIV_DW-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [gzf_pkg::DIV_NW-1:0] quot_o
);
  import gzf_pkg::*;

  div_st_e st_q, st_d;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] rem_q, dvs_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   trial;
  logic              ge, done_q;

  // quo_q shifts the dividend out at the top and quotient bits in at the bottom
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      DS_IDLE: if (start_i) st_d = DS_RUN;
      DS_RUN:  if (cnt_q == DIV_CW'(DIV_NW - 1)) st_d = DS_IDLE;
      default: st_d = DS_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (st_q != DS_IDLE);
    done_o = done_q;
    quot_o = quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DS_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == DS_RUN) && (cnt_q == DIV_CW'(DIV_NW - 1));
      if (st_q == DS_RUN) cnt_q <= cnt_q + DIV_CW'(1);
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == DS_IDLE && start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (st_q == DS_RUN) begin
      rem_q <= ge ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

endmodule

/* rtl/core/gas_z_factor_dak_solver.sv */
// Dranchuk-Abou-Kassem Z factor by successive substitution: a multiply runs 6 digit steps
// of the shared multiplier, a divide runs on the 56-bit restoring divider.
// A setup pass, then iterations (exp walk: 0..13 multiplies plus a scan of up to 12 bits
// of x); special inputs (negative pressure, zero temperature, limit 0) skip the iterations.
// One item at a time: s_axis_tready only between items, a finished result waits in the
// output register. Reset: tolerance 66, limit 20, block idle.
module gas_z_factor_dak_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // reduced_pressure[23:0], reduced_temperature[43:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // z_factor[19:0], status[22:20], iterations_used[29:23]
);
  import gzf_pkg::*;

  st_e  st_q, st_d;
  pc_e  pc_q, pc_d;
  logic [4:0]      bit_q, bit_d;
  logic [IT_W-1:0] it_q, lim_q, cfg_lim_q, lim_eff;
  logic [TOL_W-1:0] tol_q;
  logic [22:0] pr_q;
  logic [19:0] tr_q;
  val_t ti_q, t2_q, t3_q, t4_q, t5_q, c1_q, c2_q, c3_q, s_q, num_q, den_q;
  val_t z_q, rho_q, r2_q, r5_q, x_q, w_q, t4r_q, e_q, ex_q, zn_q;
  logic [19:0] res_z_q, out_z_q;
  logic [2:0]  res_st_q, out_st_q;
  logic [IT_W-1:0] res_it_q, out_it_q;
  logic out_vld_q;

  logic acc_in, in_special, unit_done, is_div;
  logic mul_start, mul_busy, mul_done, div_start, div_busy, div_done;
  mul_req_t mreq;
  val_t mul_res, madd, mprod, wsat, qsat, zc, dz;
  logic mneg;
  dst_e mdst;
  logic signed [VAL_W:0] wsum;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic conv, divg, exp_last;

  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign lim_eff = (cfg_lim_q > IT_W'(MAX_ITERATIONS)) ? IT_W'(MAX_ITERATIONS) : cfg_lim_q;
  assign in_special = s_axis_tdata[23] || (s_axis_tdata[43:24] == 20'd0) ||
                      (lim_eff == '0);
  assign is_div    = (pc_q == P_TI) || (pc_q == L_RHO);
  assign unit_done = mul_done || div_done;
  assign exp_last  = (bit_q == 5'(EXP_LOWP));

  // operand routing of each program step
  always_comb begin
    mreq = '{a: '0, b: '0, mode: MM_Q16};
    madd = '0;
    mneg = 1'b0;
    mdst = D_NONE;
    case (pc_q)
      P_T2:  begin mreq.a = ti_q;  mreq.b = ti_q; mdst = D_T2; end
      P_T3:  begin mreq.a = t2_q;  mreq.b = ti_q; mdst = D_T3; end
      P_T4:  begin mreq.a = t3_q;  mreq.b = ti_q; mdst = D_T4; end
      P_T5:  begin mreq.a = t4_q;  mreq.b = ti_q; mdst = D_T5; end
      P_C1A: begin mreq.a = C_A2;  mreq.b = ti_q; madd = C_A1; mdst = D_C1; end
      P_SA:  begin mreq.a = C_A3;  mreq.b = t3_q; mdst = D_S; end
      P_SB:  begin mreq.a = C_A4;  mreq.b = t4_q; madd = s_q; mdst = D_S; end
      P_C1B: begin mreq.a = s_q;   mreq.b = ONE;  madd = c1_q; mdst = D_C1; end
      P_C1C: begin mreq.a = C_A5;  mreq.b = t5_q; madd = c1_q; mdst = D_C1; end
      P_C2A: begin mreq.a = C_A7;  mreq.b = ti_q; madd = C_A6; mdst = D_C2; end
      P_C2B: begin mreq.a = C_A8;  mreq.b = t2_q; madd = c2_q; mdst = D_C2; end
      P_SC:  begin mreq.a = C_A7;  mreq.b = ti_q; mdst = D_S; end
      P_SD:  begin mreq.a = C_A8;  mreq.b = t2_q; madd = s_q; mdst = D_S; end
      P_C3:  begin mreq.a = C_A9;  mreq.b = s_q;  mdst = D_C3; end
      P_NUM: begin
        mreq.a = val_t'(pr_q); mreq.b = C_027; mreq.mode = MM_RAW; mdst = D_NUM;
      end
      L_DEN: begin
        mreq.a = z_q; mreq.b = val_t'(tr_q); mreq.mode = MM_RAW; mdst = D_DEN;
      end
      L_R2:  begin mreq.a = rho_q; mreq.b = rho_q; mdst = D_R2; end
      L_R4:  begin mreq.a = r2_q;  mreq.b = r2_q;  mdst = D_S; end
      L_R5:  begin mreq.a = s_q;   mreq.b = rho_q; mdst = D_R5; end
      L_X:   begin mreq.a = C_A11; mreq.b = r2_q;  mdst = D_X; end
      L_S1:  begin mreq.a = x_q;   mreq.b = ONE;   madd = ONE; mdst = D_S; end
      L_S2:  begin mreq.a = C_A10; mreq.b = s_q;   mdst = D_S; end
      L_W:   begin mreq.a = r2_q;  mreq.b = t3_q;  mdst = D_W; end
      L_T4:  begin mreq.a = s_q;   mreq.b = w_q;   mdst = D_T4R; end
      L_T4E: begin mreq.a = t4r_q; mreq.b = ex_q;  mdst = D_T4R; end
      L_ZA:  begin mreq.a = c1_q;  mreq.b = rho_q; madd = ONE; mdst = D_ZN; end
      L_ZB:  begin mreq.a = c2_q;  mreq.b = r2_q;  madd = zn_q; mdst = D_ZN; end
      L_ZC:  begin
        mreq.a = c3_q; mreq.b = r5_q; madd = zn_q; mneg = 1'b1; mdst = D_ZN;
      end
      L_ZD:  begin mreq.a = t4r_q; mreq.b = ONE;   madd = zn_q; mdst = D_ZN; end
      X_BIT: begin
        mreq.a = e_q; mreq.b = val_t'(exp_fac(4'(5'(EXP_TOPB) - bit_q)));
        mreq.mode = MM_Q24; mdst = D_E;
      end
      X_RND: begin
        mreq.a = e_q; mreq.b = val_t'(x_q[EXP_LOWP-1:0]); madd = e_q; mneg = 1'b1;
        mdst = D_EXP;
      end
      default: mdst = D_NONE;
    endcase
  end

  // saturating add behind the multiplier
  assign mprod = mneg ? -mul_res : mul_res;
  assign wsum  = {madd[VAL_W-1], madd} + {mprod[VAL_W-1], mprod};
  assign wsat  = (wsum > $signed({LIMV[VAL_W-1], LIMV})) ? LIMV :
                 (wsum < -$signed({LIMV[VAL_W-1], LIMV})) ? -LIMV : wsum[VAL_W-1:0];

  assign div_n = (pc_q == P_TI) ? (DIV_NW'(1) << 32) + DIV_NW'(tr_q[19:1])
                                : {num_q[DIV_DW-1:0], 16'd0} + DIV_NW'(den_q[DIV_DW-1:1]);
  assign div_d = (pc_q == P_TI) ? DIV_DW'(tr_q) : den_q[DIV_DW-1:0];
  assign qsat  = (div_q > DIV_NW'(LIMV)) ? LIMV : val_t'(div_q[VAL_W-1:0]);

  assign zc   = (zn_q > Z_MAXV) ? Z_MAXV : (zn_q < Z_MINV) ? Z_MINV : zn_q;
  assign dz   = (zc >= z_q) ? (zc - z_q) : (z_q - zc);
  assign conv = dz < val_t'(tol_q);
  assign divg = zc <= C_DIVG;

  gzf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .req_i  (mreq),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  gzf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  // next state
  always_comb begin
    st_d  = st_q;
    pc_d  = pc_q;
    bit_d = bit_q;
    case (st_q)
      ST_IDLE: if (acc_in) begin
        st_d = in_special ? ST_OUT : ST_ISSUE;
        pc_d = P_TI;
      end
      ST_ISSUE: st_d = ST_WAIT;
      ST_WAIT: if (unit_done) begin
        case (pc_q)
          P_NUM: st_d = ST_HEAD;
          L_T4:  st_d = ST_EXPI;
          L_ZD:  st_d = ST_CHECK;
          X_BIT: begin
            if (exp_last) begin
              pc_d = X_RND;
              st_d = ST_ISSUE;
            end else begin
              bit_d = bit_q - 5'd1;
              st_d  = ST_EXPB;
            end
          end
          X_RND: begin
            pc_d = L_T4E;
            st_d = ST_ISSUE;
          end
          default: begin
            pc_d = pc_e'(pc_q + 6'd1);
            st_d = ST_ISSUE;
          end
        endcase
      end
      ST_HEAD: begin
        pc_d = L_DEN;
        st_d = (it_q == lim_q) ? ST_OUT : ST_ISSUE;
      end
      ST_EXPI: begin
        bit_d = 5'(EXP_TOPB);
        if (x_q == '0 || x_q >= EXP_XMAX) begin
          pc_d = L_T4E;
          st_d = ST_ISSUE;
        end else begin
          st_d = ST_EXPB;
        end
      end
      ST_EXPB: begin
        if (x_q[bit_q]) begin
          pc_d = X_BIT;
          st_d = ST_ISSUE;
        end else if (exp_last) begin
          pc_d = X_RND;
          st_d = ST_ISSUE;
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end
      ST_CHECK: st_d = (conv || divg) ? ST_OUT : ST_HEAD;
      ST_OUT:   if (!out_vld_q || m_axis_tready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    mul_start     = (st_q == ST_ISSUE) && !is_div;
    div_start     = (st_q == ST_ISSUE) && is_div;
    m_axis_tvalid = out_vld_q;
    m_axis_tdata  = {2'b00, out_it_q, out_st_q, out_z_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      pc_q      <= P_TI;
      bit_q     <= '0;
      it_q      <= '0;
      out_vld_q <= 1'b0;
      tol_q     <= TOL_W'(66);
      cfg_lim_q <= IT_W'(20);
    end else begin
      st_q  <= st_d;
      pc_q  <= pc_d;
      bit_q <= bit_d;
      if (cfg_we_i && cfg_addr_i == REG_TOL) tol_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_addr_i == REG_LIM) cfg_lim_q <= cfg_wdata_i[IT_W-1:0];
      if (st_q == ST_WAIT && div_done == 1'b0 && mul_done && pc_q == P_NUM) it_q <= '0;
      if (st_q == ST_CHECK) it_q <= it_q + IT_W'(1);
      if (st_q == ST_OUT && (!out_vld_q || m_axis_tready)) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pr_q  <= s_axis_tdata[22:0];
      tr_q  <= s_axis_tdata[43:24];
      lim_q <= lim_eff;
      res_z_q  <= ONE[19:0];
      res_it_q <= '0;
      if (s_axis_tdata[23])                   res_st_q <= STAT_NEGP;
      else if (s_axis_tdata[43:24] == 20'd0)  res_st_q <= STAT_BADT;
      else                                    res_st_q <= STAT_LIMIT;
    end
    if (st_q == ST_WAIT && div_done) begin
      if (pc_q == P_TI) ti_q <= qsat;
      else rho_q <= qsat;
    end
    if (st_q == ST_WAIT && mul_done) begin
      case (mdst)
        D_T2:  t2_q  <= wsat;
        D_T3:  t3_q  <= wsat;
        D_T4:  t4_q  <= wsat;
        D_T5:  t5_q  <= wsat;
        D_C1:  c1_q  <= wsat;
        D_C2:  c2_q  <= wsat;
        D_C3:  c3_q  <= wsat;
        D_S:   s_q   <= wsat;
        D_NUM: num_q <= wsat;
        D_DEN: den_q <= wsat;
        D_R2:  r2_q  <= wsat;
        D_R5:  r5_q  <= wsat;
        D_X:   x_q   <= wsat;
        D_W:   w_q   <= wsat;
        D_T4R: t4r_q <= wsat;
        D_E:   e_q   <= wsat;
        D_EXP: ex_q  <= (wsat + 42'sd128) >>> 8;
        D_ZN:  zn_q  <= wsat;
        default: ;
      endcase
      if (pc_q == P_NUM) z_q <= ONE;
    end
    if (st_q == ST_EXPI) begin
      e_q <= EXP_ONE24;
      if (x_q == '0) ex_q <= ONE;
      else if (x_q >= EXP_XMAX) ex_q <= '0;
    end
    if (st_q == ST_HEAD && it_q == lim_q) begin
      res_z_q  <= z_q[19:0];
      res_st_q <= STAT_LIMIT;
      res_it_q <= lim_q;
    end
    if (st_q == ST_CHECK) begin
      z_q      <= zc;
      res_z_q  <= zc[19:0];
      res_st_q <= conv ? STAT_CONV : STAT_DIVG;
      res_it_q <= it_q + IT_W'(1);
    end
    if (st_q == ST_OUT && (!out_vld_q || m_axis_tready)) begin
      out_z_q  <= res_z_q;
      out_st_q <= res_st_q;
      out_it_q <= res_it_q;
    end
  end

  a_one_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done)) else $error("multiplier and divider finished together");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_z_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CHECK) |-> (z_q > C_DIVG)) else $error("iterating on a diverged Z");

  a_it_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_HEAD) |-> (it_q <= lim_q)) else $error("iteration count past limit");

endmodule

/* tb/gas_z_factor_dak_solver_tb.sv */
// Testbench for gas_z_factor_dak_solver: directed and random requests checked against
// a fixed-point DAK predictor held in the bench. Depends on gzf_pkg and the solver RTL.
module gas_z_factor_dak_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gzf_pkg::*;

  typedef struct {
    logic signed [19:0] z;
    logic [2:0]         st;
    logic [6:0]         its;
  } z_result_t;

  localparam longint SAT_LIM = 64'sh100_0000_0000;
  localparam longint unsigned PROD_CAP = 64'h0100_0000_0000_0000;
  // exp(-2^k) in Q24, k = 3 down to -12
  localparam longint unsigned EXP_FACTOR [16] = '{
    5628, 307285, 2270549, 6171993, 10175896, 13066109, 14805841,
    15760736, 16261035, 16517109, 16646655, 16711779, 16744480,
    16760840, 16769026, 16773120};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // reduced_pressure[23:0], reduced_temperature[43:24]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;      // z_factor[19:0], status[22:20], iterations_used[29:23]

  gas_z_factor_dak_solver dut (.*);

  always #2 clk_i = ~clk_i;

  z_result_t   z_expected [$];
  int unsigned tol_reg = 66;
  int unsigned lim_reg = 20;
  int          mismatches = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          hold_req = 0;

  // ---------------- predictor ----------------
  function automatic longint sat_q16(longint v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic longint add_q16(longint a, longint b);
    return sat_q16(sat_q16(a) + sat_q16(b));
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, q;
    a = sat_q16(a);
    b = sat_q16(b);
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if (ma == 0 || mb == 0) return 0;
    if (mb > PROD_CAP / ma) return neg ? -SAT_LIM : SAT_LIM;
    q = (ma * mb + 64'd32768) >> 16;
    if (q > SAT_LIM) q = SAT_LIM;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint exp_neg_q16(longint x);
    longint unsigned ux, acc, r;
    if (x <= 0) return 65536;
    if (x >= (longint'(16) << 16)) return 0;
    ux = x;
    acc = 64'd1 << 24;
    for (int p = 19; p >= EXP_LOWP; p--)
      if (ux[p]) acc = (acc * EXP_FACTOR[19-p] + (64'd1 << 23)) >> 24;
    r = ux & ((64'd1 << EXP_LOWP) - 1);
    acc -= (acc * r + 64'd32768) >> 16;
    return longint'((acc + 64'd128) >> 8);
  endfunction

  function automatic z_result_t predict_z(logic [47:0] item);
    logic signed [23:0] pr;
    longint unsigned    tr, lim, num, den, q;
    longint             ti, ti2, ti3, ti4, ti5, c1, c2, c3, z, rho, r2, r5, t4, zn, d;
    z_result_t          res;
    pr = item[23:0];
    tr = {44'd0, item[43:24]};
    lim = (lim_reg > MAX_ITERATIONS) ? MAX_ITERATIONS : lim_reg;
    res.z = 20'sd65536;
    res.its = '0;
    if (pr < 0) begin
      res.st = STAT_NEGP;
      return res;
    end
    if (tr == 0) begin
      res.st = STAT_BADT;
      return res;
    end
    ti  = ((64'd1 << 32) + tr / 2) / tr;
    ti2 = mul_q16(ti, ti);
    ti3 = mul_q16(ti2, ti);
    ti4 = mul_q16(ti3, ti);
    ti5 = mul_q16(ti4, ti);
    c1 = add_q16(add_q16(add_q16(C_A1, mul_q16(C_A2, ti)),
                         add_q16(mul_q16(C_A3, ti3), mul_q16(C_A4, ti4))),
                 mul_q16(C_A5, ti5));
    c2 = add_q16(add_q16(C_A6, mul_q16(C_A7, ti)), mul_q16(C_A8, ti2));
    c3 = mul_q16(C_A9, add_q16(mul_q16(C_A7, ti), mul_q16(C_A8, ti2)));
    num = 64'd17695 * longint'(pr);
    z = 65536;
    for (longint unsigned i = 0; i < lim; i++) begin
      den = longint'(z) * tr;
      q = ((num << 16) + den / 2) / den;
      if (q > SAT_LIM) q = SAT_LIM;
      rho = q;
      r2 = mul_q16(rho, rho);
      r5 = mul_q16(mul_q16(r2, r2), rho);
      t4 = mul_q16(mul_q16(C_A10, add_q16(65536, mul_q16(C_A11, r2))), mul_q16(r2, ti3));
      t4 = mul_q16(t4, exp_neg_q16(mul_q16(C_A11, r2)));
      zn = add_q16(65536, mul_q16(c1, rho));
      zn = add_q16(zn, mul_q16(c2, r2));
      zn = add_q16(zn, -mul_q16(c3, r5));
      zn = add_q16(zn, t4);
      if (zn > 524287) zn = 524287;
      if (zn < -524288) zn = -524288;
      d = (zn > z) ? zn - z : z - zn;
      res.its = 7'(i + 1);
      if (d < tol_reg) begin
        res.z = 20'(zn);
        res.st = STAT_CONV;
        return res;
      end
      z = zn;
      if (z <= C_DIVG) begin
        res.z = 20'(z);
        res.st = STAT_DIVG;
        return res;
      end
    end
    res.z = 20'(z);
    res.st = STAT_LIMIT;
    res.its = 7'(lim);
    return res;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk_i) begin
    int hold_cnt;
    int phase;
    z_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (z_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        exp_r = z_expected.pop_front();
        if (m_axis_tdata[19:0] !== exp_r.z || m_axis_tdata[22:20] !== exp_r.st ||
            m_axis_tdata[29:23] !== exp_r.its) begin
          mismatches++;
          if (mismatches <= 10)
            $display("z/status/iters expected %0d/%0d/%0d got %0d/%0d/%0d",
                     exp_r.z, exp_r.st, exp_r.its, $signed(m_axis_tdata[19:0]),
                     m_axis_tdata[22:20], m_axis_tdata[29:23]);
        end
      end
    end
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    phase++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= (phase % 11) < 6;
      default: m_axis_tready <= $urandom_range(0, 2) != 0;
    endcase
  end

  // ---------------- request side ----------------
  task automatic send_item(logic [47:0] item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    z_expected.push_back(predict_z(item));
  endtask

  task automatic drain();
    while (z_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [15:0] data);
    s_axis_tvalid <= 1'b0;
    drain();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == REG_TOL) tol_reg = {16'd0, data};
    else lim_reg = {25'd0, data[6:0]};
  endtask

  function automatic logic [47:0] make_item(int kind);
    logic [23:0] p;
    logic [19:0] t;
    p = 24'($urandom_range(0, 983040));          // 0 .. 15.0
    t = 20'($urandom_range(68813, 196608));      // 1.05 .. 3.0
    case (kind)
      0: begin
        p = 24'($urandom);
        t = 20'($urandom);
      end
      1: p = -24'($urandom_range(1, 8388608));
      2: t = '0;
      default: ;
    endcase
    return {4'b0, t, p};
  endfunction

  // ---------------- tests ----------------
  task automatic test_special_inputs();
    send_item({4'b0, 20'd65536, 24'h800000});
    send_item({4'b0, 20'd0, 24'hFFFFFF});
    send_item({4'b0, 20'd0, 24'd65536});
    send_item({4'b0, 20'd0, 24'h800000});
    send_item({4'b0, 20'd0, 24'd0});
    send_item({4'b0, 20'd98304, 24'd0});
    send_item({4'b0, 20'd1, 24'h7FFFFF});
    send_item({4'b0, 20'hFFFFF, 24'h7FFFFF});
    send_item({4'b0, 20'hFFFFF, 24'd1});
    send_item({4'b0, 20'd1, 24'd1});
    send_item({4'b0, 20'd70000, 24'd1000000});
    send_item({4'b0, 20'd110000, 24'd300000});
    send_item({4'b0, 20'd68813, 24'd983040});
  endtask

  task automatic test_register_extremes();
    write_reg(REG_LIM, 16'd0);
    send_item({4'b0, 20'd98304, 24'd131072});
    send_item({4'b0, 20'd0, 24'hFFFFFF});
    write_reg(REG_LIM, 16'hFF7F);           // 127: clipped to the maximum
    write_reg(REG_TOL, 16'd1);
    send_item({4'b0, 20'd98304, 24'd131072});
    send_item({4'b0, 20'd68813, 24'd600000});
    write_reg(REG_TOL, 16'd0);              // never converges
    write_reg(REG_LIM, 16'd3);
    send_item({4'b0, 20'd98304, 24'd131072});
    send_item({4'b0, 20'd131072, 24'd0});
    write_reg(REG_TOL, 16'hFFFF);
    write_reg(REG_LIM, 16'd64);
    send_item({4'b0, 20'd98304, 24'd131072});
    send_item({4'b0, 20'd1, 24'h7FFFFF});
  endtask

  task automatic run_phase(int tol, int lim, int count, int mode, bit with_hold);
    write_reg(REG_TOL, 16'(tol));
    write_reg(REG_LIM, 16'(lim));
    rx_mode = mode;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 10) hold_req = 3000;
      if (n == count / 2) begin
        s_axis_tvalid <= 1'b0;
        drain();
      end
      send_item(make_item($urandom_range(0, 11)));
    end
  endtask

  task automatic test_random_items();
    run_phase(66, 2, 650, 0, 1'b1);
    run_phase(1000, 4, 400, 1, 1'b0);
    run_phase(66, 20, 250, 2, 1'b1);
    run_phase($urandom_range(1, 65535), $urandom_range(1, 8), 100, 2, 1'b0);
    run_phase(5, 64, 60, 1, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_inputs();
    test_register_extremes();
    test_random_items();
    s_axis_tvalid <= 1'b0;
    while (z_expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("gas_z_factor_dak_solver: match");
    else $display("gas_z_factor_dak_solver: mismatch");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("gas_z_factor_dak_solver: mismatch");
    $finish;
  end

endmodule
